// ===== rtl/core/bam_pkg.sv =====
// Package for the bitmap allocation map: action codes, controller states
// and word geometry constants. No dependencies.
package bam_pkg;

    // Map word geometry: eight bytes per memory word.
    localparam int BYTES_PER_WORD = 8;
    localparam int WORD_BITS      = 64;

    // Field widths fixed by the item format.
    localparam int SIZE_W   = 10;
    localparam int BITNO_W  = 12;
    localparam int ACTION_W = 2;

    // Action codes of an input beat.
    typedef enum logic [ACTION_W-1:0] {
        ACT_SET       = 2'd0,
        ACT_CLEAR     = 2'd1,
        ACT_FIND_ZERO = 2'd2,
        ACT_FIND_ONE  = 2'd3
    } action_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/bam_mem.sv =====
// Map storage: one write port and one read port with registered read data.
// Depends on bam_pkg for the word width.
module bam_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [ADDR_W-1:0]              wr_addr,
    input  logic [bam_pkg::WORD_BITS-1:0]  wr_data,
    input  logic                           rd_en,
    input  logic [ADDR_W-1:0]              rd_addr,
    output logic [bam_pkg::WORD_BITS-1:0]  rd_data
);

    logic [bam_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [bam_pkg::WORD_BITS-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bam_find.sv =====
// Finds the lowest matching bit in one 64-bit map word, limited to the
// bytes flagged as in use. Depends on bam_pkg for the word geometry.
module bam_find (
    input  logic [bam_pkg::WORD_BITS-1:0]       word_data,
    input  logic                                want_one,
    input  logic [bam_pkg::BYTES_PER_WORD-1:0]  byte_ok,
    output logic                                hit,
    output logic [5:0]                          bit_idx
);

    logic [bam_pkg::WORD_BITS-1:0]      probe;
    logic [bam_pkg::BYTES_PER_WORD-1:0] byte_nz;
    logic [2:0]                         byte_sel;
    logic [7:0]                         sel_byte;
    logic [2:0]                         bit_sel;
    logic                               bit_hit;

    // Turn the search into a search for ones and drop bytes out of range.
    always_comb begin
        probe = want_one ? word_data : ~word_data;
        for (int j = 0; j < bam_pkg::BYTES_PER_WORD; j++) begin
            byte_nz[j] = byte_ok[j] && (probe[j*8 +: 8] != 8'h00);
        end
    end

    // First level: lowest byte that holds a match.
    always_comb begin
        byte_sel = 3'd0;
        for (int j = bam_pkg::BYTES_PER_WORD - 1; j >= 0; j--) begin
            if (byte_nz[j]) begin
                byte_sel = 3'(j);
            end
        end
        sel_byte = probe[byte_sel*8 +: 8];
    end

    // Second level: lowest matching bit inside that byte.
    always_comb begin
        bit_sel = 3'd0;
        bit_hit = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            if (sel_byte[k]) begin
                bit_sel = 3'(k);
                bit_hit = 1'b1;
            end
        end
    end

    assign hit     = (byte_nz != '0) && bit_hit;
    assign bit_idx = {byte_sel, bit_sel};

endmodule

// ===== rtl/core/bitmap_allocation_map.sv =====
// A set or clear beat goes from acceptance through a memory read, a write back and the output
// load to a result beat. A set or clear that names a bit out of range skips the memory. A
// search reads one 64-bit word (eight map bytes) per cycle through the single read port, up
// to ceil(bytes_in_use / 8) words, and still reads word 0 for a size of zero. Sizes above
// MAX_BYTES count as MAX_BYTES. One beat is in work at a time. The output register lets the
// next beat be accepted while a result waits; a finished beat holds in its last cycle until
// the waiting result is taken. After reset a clearing pass writes zero to every word, during
// which no beat is accepted; configuration writes are taken at any time.
// Depends on bam_pkg, bam_mem and bam_find.
module bitmap_allocation_map #(
    parameter int MAX_BYTES = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bam_pkg::SIZE_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bam_pkg::ACTION_W-1:0]  s_action,
    input  logic [bam_pkg::BITNO_W-1:0]   s_bit_number,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [bam_pkg::BITNO_W-1:0]   m_position,
    output logic                          m_out_of_range
);

    localparam int WORDS  = (MAX_BYTES + bam_pkg::BYTES_PER_WORD - 1) /
                            bam_pkg::BYTES_PER_WORD;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CMP_W  = (ADDR_W + 4 > 11) ? ADDR_W + 4 : 11;
    localparam logic [16:0] MAX_B = 17'(MAX_BYTES);

    bam_pkg::state_t state_reg, state_next;

    logic [bam_pkg::SIZE_W-1:0]   cfg_reg;
    logic [bam_pkg::SIZE_W-1:0]   active;
    logic [bam_pkg::ACTION_W-1:0] act_reg, act_next;
    logic [bam_pkg::BITNO_W-1:0]  bit_reg, bit_next;
    logic [ADDR_W-1:0]            word_reg, word_next;
    logic [ADDR_W-1:0]            clr_reg, clr_next;
    logic                         res_found_reg, res_found_next;
    logic [bam_pkg::BITNO_W-1:0]  res_pos_reg, res_pos_next;
    logic                         res_oor_reg, res_oor_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         m_found_reg, m_found_next;
    logic [bam_pkg::BITNO_W-1:0]  m_pos_reg, m_pos_next;
    logic                         m_oor_reg, m_oor_next;

    logic                            accept;
    logic                            in_update;
    logic                            in_oor;
    logic                            look_update;
    logic                            look_last;
    logic                            out_free;
    logic [CMP_W-1:0]                word_base;
    logic [bam_pkg::BYTES_PER_WORD-1:0] byte_ok;
    logic                            find_hit;
    logic [5:0]                      find_idx;
    logic [bam_pkg::WORD_BITS-1:0]   bit_mask;

    logic                            wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [bam_pkg::WORD_BITS-1:0]   wr_data;
    logic                            rd_en;
    logic [ADDR_W-1:0]               rd_addr;
    logic [bam_pkg::WORD_BITS-1:0]   rd_data;

    // Size register, written whenever the enable is high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= 10'd512;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // Bytes covered, limited to the size of the store.
    assign active = ({7'd0, cfg_reg} > MAX_B) ? bam_pkg::SIZE_W'(MAX_B) : cfg_reg;

    // Input decode.
    assign accept    = s_valid && s_ready;
    assign in_update = (s_action == bam_pkg::ACT_SET) || (s_action == bam_pkg::ACT_CLEAR);
    assign in_oor    = {1'b0, s_bit_number[bam_pkg::BITNO_W-1:3]} >= active;
    assign out_free  = !m_valid_reg || m_ready;

    // Scan bookkeeping for the word whose data is on the read port.
    assign look_update = (act_reg == bam_pkg::ACT_SET) || (act_reg == bam_pkg::ACT_CLEAR);
    assign word_base   = CMP_W'({word_reg, 3'b000});
    assign look_last   = (word_base + CMP_W'(bam_pkg::BYTES_PER_WORD)) >= CMP_W'(active);

    always_comb begin
        for (int j = 0; j < bam_pkg::BYTES_PER_WORD; j++) begin
            byte_ok[j] = (word_base + CMP_W'(j)) < CMP_W'(active);
        end
    end

    bam_find u_find (
        .word_data (rd_data),
        .want_one  (act_reg == bam_pkg::ACT_FIND_ONE),
        .byte_ok   (byte_ok),
        .hit       (find_hit),
        .bit_idx   (find_idx)
    );

    assign bit_mask = bam_pkg::WORD_BITS'(1) << bit_reg[5:0];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bam_pkg::ST_CLEAR: begin
                if (clr_reg == ADDR_W'(WORDS - 1)) begin
                    state_next = bam_pkg::ST_IDLE;
                end
            end
            bam_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (in_update && in_oor) ? bam_pkg::ST_DONE : bam_pkg::ST_LOOK;
                end
            end
            bam_pkg::ST_LOOK: begin
                if (look_update || find_hit || look_last) begin
                    state_next = bam_pkg::ST_DONE;
                end
            end
            bam_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bam_pkg::ST_IDLE;
                end
            end
            default: state_next = bam_pkg::ST_IDLE;
        endcase
    end

    // Memory controls and input ready.
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = '0;
        case (state_reg)
            bam_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
            end
            bam_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                rd_en   = s_valid && !(in_update && in_oor);
                rd_addr = in_update ? ADDR_W'(s_bit_number[bam_pkg::BITNO_W-1:6]) : '0;
            end
            bam_pkg::ST_LOOK: begin
                if (look_update) begin
                    wr_en   = 1'b1;
                    wr_addr = word_reg;
                    wr_data = (act_reg == bam_pkg::ACT_SET) ? (rd_data | bit_mask)
                                                             : (rd_data & ~bit_mask);
                end else begin
                    rd_en   = !find_hit && !look_last;
                    rd_addr = word_reg + ADDR_W'(1);
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        act_next       = act_reg;
        bit_next       = bit_reg;
        word_next      = word_reg;
        clr_next       = clr_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_oor_next   = res_oor_reg;
        m_valid_next   = m_valid_reg;
        m_found_next   = m_found_reg;
        m_pos_next     = m_pos_reg;
        m_oor_next     = m_oor_reg;

        if (state_reg == bam_pkg::ST_CLEAR) begin
            clr_next = clr_reg + ADDR_W'(1);
        end

        if (accept) begin
            act_next       = s_action;
            bit_next       = s_bit_number;
            word_next      = in_update ? ADDR_W'(s_bit_number[bam_pkg::BITNO_W-1:6]) : '0;
            res_found_next = 1'b0;
            res_pos_next   = '0;
            res_oor_next   = in_update && in_oor;
        end

        if (state_reg == bam_pkg::ST_LOOK && !look_update) begin
            if (find_hit) begin
                res_found_next = 1'b1;
                res_pos_next   = bam_pkg::BITNO_W'({word_reg, find_idx});
            end else if (!look_last) begin
                word_next = word_reg + ADDR_W'(1);
            end
        end

        // Output register.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == bam_pkg::ST_DONE && out_free) begin
            m_valid_next = 1'b1;
            m_found_next = res_found_reg;
            m_pos_next   = res_pos_reg;
            m_oor_next   = res_oor_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bam_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        bit_reg       <= bit_next;
        word_reg      <= word_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_oor_reg   <= res_oor_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
        m_oor_reg     <= m_oor_next;
    end

    bam_mem #(
        .DEPTH  (WORDS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_position     = m_pos_reg;
    assign m_out_of_range = m_oor_reg;

    // A result beat never reports both a hit and an out-of-range update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_out_of_range))
        else $error("found and out_of_range both set");

    // A miss or an update reports position zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_position == '0))
        else $error("nonzero position without a hit");

    // A search never writes the map.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bam_pkg::ST_LOOK && !look_update) |-> !wr_en)
        else $error("map written during a search");

    // Only one beat is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted while a beat is in work");

    // The read and write ports never touch the same word in one cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write collide on one word");

endmodule

// ===== tb/sv/tb_bitmap_allocation_map.sv =====
// Self-checking testbench for bitmap_allocation_map: set, clear and find-first beats
// checked against an in-bench copy of the map, under several sizes and idling patterns.
// Depends on bam_pkg and the bitmap_allocation_map RTL.
module tb_bitmap_allocation_map;

    localparam int MAP_BYTES    = 512;
    localparam int REPORT_LIMIT = 50;

    typedef struct packed {
        logic                         found;
        logic [bam_pkg::BITNO_W-1:0]  position;
        logic                         out_of_range;
    } map_result_t;

    logic                         aclk           = 1'b0;
    logic                         aresetn        = 1'b0;
    logic                         cfg_wr_en      = 1'b0;
    logic [bam_pkg::SIZE_W-1:0]   cfg_wr_data    = '0;
    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic [bam_pkg::ACTION_W-1:0] s_action       = bam_pkg::ACT_SET;
    logic [bam_pkg::BITNO_W-1:0]  s_bit_number   = '0;
    logic                         m_valid;
    logic                         m_ready        = 1'b0;
    logic                         m_found;
    logic [bam_pkg::BITNO_W-1:0]  m_position;
    logic                         m_out_of_range;

    // Bench copy of the map and its size register.
    logic [7:0]                   map_bytes [MAP_BYTES];
    logic [bam_pkg::SIZE_W-1:0]   map_size;
    map_result_t                  expected_results [$];
    int                           error_count;
    int                           send_idle_pct;
    int                           recv_stall_pct;

    bitmap_allocation_map #(
        .MAX_BYTES(MAP_BYTES)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_bit_number  (s_bit_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_position    (m_position),
        .m_out_of_range(m_out_of_range)
    );

    always #2 aclk = ~aclk;

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // Applies one beat to the bench map and returns the result it must produce.
    function automatic map_result_t predict_action(bam_pkg::action_t act,
                                                   logic [bam_pkg::BITNO_W-1:0] bitno);
        map_result_t res;
        int          active;
        int          byte_idx;
        logic [7:0]  probe;
        res = '0;
        active = (map_size > MAP_BYTES) ? MAP_BYTES : int'(map_size);
        if (act == bam_pkg::ACT_SET || act == bam_pkg::ACT_CLEAR) begin
            byte_idx = int'(bitno >> 3);
            if (byte_idx >= active) begin
                res.out_of_range = 1'b1;
            end else begin
                map_bytes[byte_idx][bitno[2:0]] = (act == bam_pkg::ACT_SET);
            end
        end else begin
            // Scan bytes upward; within a byte the lowest matching bit wins.
            for (int i = 0; i < active && !res.found; i++) begin
                probe = (act == bam_pkg::ACT_FIND_ONE) ? map_bytes[i] : ~map_bytes[i];
                for (int k = 7; k >= 0; k--) begin
                    if (probe[k]) begin
                        res.position = bam_pkg::BITNO_W'(i * 8 + k);
                    end
                end
                res.found = (probe != 8'h00);
            end
        end
        return res;
    endfunction

    // Result checker: every result beat is matched against the oldest expectation.
    always @(posedge aclk) begin
        map_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with no pending expectation");
            end else begin
                exp_res = expected_results.pop_front();
                if (m_found !== exp_res.found) begin
                    report_mismatch($sformatf("found: expected %0d, got %0b",
                        exp_res.found, m_found));
                end
                if (m_position !== exp_res.position) begin
                    report_mismatch($sformatf("position: expected %0d, got %0d",
                        exp_res.position, m_position));
                end
                if (m_out_of_range !== exp_res.out_of_range) begin
                    report_mismatch($sformatf("out_of_range: expected %0d, got %0b",
                        exp_res.out_of_range, m_out_of_range));
                end
            end
        end
    end

    // Sends one beat, with a random idle gap first; valid stays high after acceptance.
    task automatic send_action(bam_pkg::action_t act, logic [bam_pkg::BITNO_W-1:0] bitno);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_bit_number <= bitno;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_action(act, bitno));
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Writes the size register while the block is idle.
    task automatic write_size(logic [bam_pkg::SIZE_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        map_size = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Empty map at the default size: nothing set, bit 0 clear.
    task automatic test_reset_state();
        send_action(bam_pkg::ACT_FIND_ONE, '0);
        send_action(bam_pkg::ACT_FIND_ZERO, '1);
    endtask

    // Lowest and highest bit of the full-size map.
    task automatic test_update_extremes();
        send_action(bam_pkg::ACT_SET, 12'd0);
        send_action(bam_pkg::ACT_SET, 12'd4095);
        send_action(bam_pkg::ACT_FIND_ONE, 12'd0);
        send_action(bam_pkg::ACT_CLEAR, 12'd0);
        send_action(bam_pkg::ACT_FIND_ONE, 12'd0);
        send_action(bam_pkg::ACT_FIND_ZERO, 12'd4095);
    endtask

    // Size of one byte, size of zero, and sizes above the map.
    task automatic test_size_limits();
        write_size(10'd1);
        for (int b = 0; b < 8; b++) begin
            send_action(bam_pkg::ACT_SET, bam_pkg::BITNO_W'(b));
        end
        send_action(bam_pkg::ACT_FIND_ZERO, 12'd0);
        send_action(bam_pkg::ACT_SET, 12'd8);
        send_action(bam_pkg::ACT_CLEAR, 12'd4095);
        write_size(10'd0);
        send_action(bam_pkg::ACT_SET, 12'd0);
        send_action(bam_pkg::ACT_FIND_ZERO, 12'd0);
        write_size(10'd1023);
        send_action(bam_pkg::ACT_FIND_ZERO, 12'd0);
        send_action(bam_pkg::ACT_CLEAR, 12'd4095);
        write_size(10'd513);
        send_action(bam_pkg::ACT_FIND_ONE, 12'd0);
    endtask

    // Picks a bit mostly inside a small low window of the active map.
    function automatic logic [bam_pkg::BITNO_W-1:0] pick_bit_number();
        int active;
        int window;
        active = (map_size > MAP_BYTES) ? MAP_BYTES : int'(map_size);
        window = (active * 8 > 64) ? 64 : active * 8;
        if (window > 0 && $urandom_range(0, 99) < 85) begin
            return bam_pkg::BITNO_W'($urandom_range(0, window - 1));
        end
        return bam_pkg::BITNO_W'($urandom_range(0, 4095));
    endfunction

    // Random traffic in four idling phases, with the size changed every block of beats.
    task automatic test_random_traffic();
        int               roll;
        bam_pkg::action_t act;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 50;
                end
                default: begin
                    send_idle_pct = 15;
                    recv_stall_pct = 15;
                end
            endcase
            for (int blk = 0; blk < 5; blk++) begin
                roll = $urandom_range(0, 9);
                case (roll)
                    0: write_size(10'd0);
                    1: write_size(bam_pkg::SIZE_W'(MAP_BYTES));
                    2: write_size(10'd1023);
                    3: write_size(10'd513);
                    4: write_size(bam_pkg::SIZE_W'($urandom_range(1, 1023)));
                    default: write_size(bam_pkg::SIZE_W'($urandom_range(1, 8)));
                endcase
                for (int n = 0; n < 50; n++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 35) begin
                        act = bam_pkg::ACT_SET;
                    end else if (roll < 60) begin
                        act = bam_pkg::ACT_CLEAR;
                    end else if (roll < 80) begin
                        act = bam_pkg::ACT_FIND_ZERO;
                    end else begin
                        act = bam_pkg::ACT_FIND_ONE;
                    end
                    send_action(act, pick_bit_number());
                end
            end
        end
    endtask

    // Test sequence.
    initial begin
        for (int i = 0; i < MAP_BYTES; i++) begin
            map_bytes[i] = 8'h00;
        end
        map_size       = bam_pkg::SIZE_W'(MAP_BYTES);
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_update_extremes();
        test_size_limits();
        test_random_traffic();

        drain_results();
        repeat (80) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== bitmap_allocation_map.f =====
rtl/core/bam_pkg.sv
rtl/core/bam_mem.sv
rtl/core/bam_find.sv
rtl/core/bitmap_allocation_map.sv
tb/sv/tb_bitmap_allocation_map.sv
